[hdl/src_pkg.sv]
// Shared types and constants for the segment rectangle clipper.
`default_nettype none

package src_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int QUO_W   = COORD_W + 2;
    localparam int REM_W   = COORD_W + 2;
    localparam int ADDR_W  = 4;
    localparam int NUM_SIDES = 4;

    localparam logic [2:0] ST_OUTSIDE = 3'd0;
    localparam logic [2:0] ST_INSIDE  = 3'd1;
    localparam logic [2:0] ST_START   = 3'd2;
    localparam logic [2:0] ST_END     = 3'd3;
    localparam logic [2:0] ST_BOTH    = 3'd4;

    localparam logic [1:0] REG_MIN_X = 2'd0;
    localparam logic [1:0] REG_MAX_X = 2'd1;
    localparam logic [1:0] REG_MIN_Y = 2'd2;
    localparam logic [1:0] REG_MAX_Y = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } seg_t;

    typedef struct packed {
        logic [2:0]                clip_status;
        logic signed [COORD_W-1:0] out_start_x;
        logic signed [COORD_W-1:0] out_start_y;
        logic signed [COORD_W-1:0] out_end_x;
        logic signed [COORD_W-1:0] out_end_y;
    } clip_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0]  len;
        logic signed [DIFF_W-1:0]  a;
        logic signed [DIFF_W-1:0]  w;
        logic signed [DIFF_W-1:0]  du;
        logic signed [DIFF_W-1:0]  dv;
        logic signed [COORD_W-1:0] v1;
    } side_in_t;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] hv;
    } side_out_t;

endpackage

`default_nettype wire

[hdl/src_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module src_div (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [src_pkg::PROD_W-1:0]  num,
    input  wire logic [src_pkg::DIFF_W-1:0]  den,
    output logic      [src_pkg::QUO_W-1:0]   quo
);

    localparam int QW = src_pkg::QUO_W;
    localparam int RW = src_pkg::REM_W;
    localparam int PW = src_pkg::PROD_W;
    localparam int DW = src_pkg::DIFF_W;

    logic [RW-1:0] rem_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [PW-1:0] num_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [RW-1:0] rem_next [QW];
    logic [QW-1:0] quo_next [QW];
    logic [PW-1:0] num_next [QW];
    logic [DW-1:0] den_next [QW];

    genvar i;
    generate
        for (i = 0; i < QW; i++)
        begin : g_step
            logic [RW-1:0] rem_prev;
            logic [QW-1:0] quo_prev;
            logic [RW-1:0] trial;
            logic          ge;
            if (i == 0)
            begin : g_first
                assign rem_prev    = RW'(num[PW-1:QW]);
                assign quo_prev    = '0;
                assign num_next[i] = num;
                assign den_next[i] = den;
            end
            else
            begin : g_rest
                assign rem_prev    = rem_reg[i-1];
                assign quo_prev    = quo_reg[i-1];
                assign num_next[i] = num_reg[i-1];
                assign den_next[i] = den_reg[i-1];
            end
            always_comb
            begin
                trial       = {rem_prev[RW-2:0], num_next[i][QW-1-i]};
                ge          = trial >= {1'b0, den_next[i]};
                rem_next[i] = ge ? trial - {1'b0, den_next[i]} : trial;
                quo_next[i] = {quo_prev[QW-2:0], ge};
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                num_reg[k] <= num_next[k];
                den_reg[k] <= den_next[k];
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

`default_nettype wire

[hdl/src_side.sv]
// Hit test and hit coordinate for one rectangle side.
`default_nettype none

module src_side (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire src_pkg::side_in_t  side_in,
    output src_pkg::side_out_t      side_out
);

    localparam int CW = src_pkg::COORD_W;
    localparam int DW = src_pkg::DIFF_W;
    localparam int PW = src_pkg::PROD_W;
    localparam int SW = src_pkg::SUM_W;
    localparam int QW = src_pkg::QUO_W;

    function automatic logic in_unit(input logic signed [SW-1:0] n,
                                     input logic signed [SW-1:0] d);
        logic r;
        if (d > 0)
            r = (n >= 0) && (n <= d);
        else
            r = (n <= 0) && (n >= d);
        return r;
    endfunction

    // stage A: products
    logic signed [PW-1:0] den_reg, na_reg, p1_reg, p2_reg;
    logic        [PW-1:0] num_reg;
    logic        [DW-1:0] dmag_reg;
    logic        [DW-1:0] amag, dvmag, dumag;
    logic                 neg_next;

    always_comb
    begin
        amag     = side_in.a[DW-1]  ? DW'(-side_in.a)  : DW'(side_in.a);
        dvmag    = side_in.dv[DW-1] ? DW'(-side_in.dv) : DW'(side_in.dv);
        dumag    = side_in.du[DW-1] ? DW'(-side_in.du) : DW'(side_in.du);
        neg_next = side_in.a[DW-1] ^ side_in.dv[DW-1] ^ side_in.du[DW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg  <= PW'(side_in.len) * PW'(side_in.du);
            na_reg   <= PW'(side_in.len) * PW'(side_in.a);
            p1_reg   <= PW'(side_in.du) * PW'(side_in.w);
            p2_reg   <= PW'(side_in.dv) * PW'(side_in.a);
            num_reg  <= PW'(amag) * PW'(dvmag);
            dmag_reg <= dumag;
        end
    end

    // neg and v1 follow stage A down the divider
    logic              neg_pipe_reg [QW+1];
    logic [CW-1:0]     v1_pipe_reg  [QW+1];
    logic              hit_pipe_reg [QW];
    logic signed [SW-1:0] nb, den_w, na_w;
    logic              hit_next;

    always_comb
    begin
        nb       = SW'(p1_reg) + SW'(p2_reg);
        den_w    = SW'(den_reg);
        na_w     = SW'(na_reg);
        hit_next = (den_reg != '0) && in_unit(na_w, den_w) && in_unit(nb, den_w);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_pipe_reg[0] <= neg_next;
            v1_pipe_reg[0]  <= side_in.v1;
            hit_pipe_reg[0] <= hit_next;
            for (int k = 1; k <= QW; k++)
            begin
                neg_pipe_reg[k] <= neg_pipe_reg[k-1];
                v1_pipe_reg[k]  <= v1_pipe_reg[k-1];
            end
            for (int k = 1; k < QW; k++)
                hit_pipe_reg[k] <= hit_pipe_reg[k-1];
        end
    end

    logic [QW-1:0] quo;

    src_div u_div (
        .clk (clk),
        .en  (en),
        .num (num_reg),
        .den (dmag_reg),
        .quo (quo)
    );

    src_pkg::side_out_t out_reg, out_next;
    logic [CW-1:0]      qlow;

    always_comb
    begin
        qlow         = quo[CW-1:0];
        out_next.hit = hit_pipe_reg[QW-1];
        out_next.hv  = neg_pipe_reg[QW] ? v1_pipe_reg[QW] - qlow
                                         : v1_pipe_reg[QW] + qlow;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign side_out = out_reg;

endmodule

`default_nettype wire

[hdl/segment_rectangle_clipper_top.sv]
// Top level of the segment rectangle clipper: register file, pipeline control, hit merge.
//
//  channel   dir  handshake             payload
//  seg       in   seg_valid/seg_stall   src_pkg::seg_t
//  clip      out  clip_valid/clip_stall src_pkg::clip_t
//  apb       in   psel/penable/pready   paddr, pwdata, prdata
//
// One segment per cycle while no stalled result holds the pipeline; each result passes through
// the 34-stage quotient pipeline plus four other register stages before clip_valid rises.
// Reset clears valid bits and the rectangle registers to zero.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none

module segment_rectangle_clipper_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          seg_valid,
    output logic                               seg_stall,
    input  wire src_pkg::seg_t                 seg,
    output logic                               clip_valid,
    input  wire logic                          clip_stall,
    output src_pkg::clip_t                     clip,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [src_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);

    localparam int CW  = src_pkg::COORD_W;
    localparam int DW  = src_pkg::DIFF_W;
    localparam int NS  = src_pkg::NUM_SIDES;
    localparam int LAT = src_pkg::QUO_W + 2;

    function automatic logic signed [DW-1:0] dif(input logic signed [CW-1:0] p,
                                                 input logic signed [CW-1:0] q);
        return DW'(p) - DW'(q);
    endfunction

    // register file
    logic signed [CW-1:0] mnx_reg, mxx_reg, mny_reg, mxy_reg;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mnx_reg <= '0;
            mxx_reg <= '0;
            mny_reg <= '0;
            mxy_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                src_pkg::REG_MIN_X: mnx_reg <= pwdata;
                src_pkg::REG_MAX_X: mxx_reg <= pwdata;
                src_pkg::REG_MIN_Y: mny_reg <= pwdata;
                src_pkg::REG_MAX_Y: mxy_reg <= pwdata;
                default:            mnx_reg <= mnx_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            src_pkg::REG_MIN_X: prdata = mnx_reg;
            src_pkg::REG_MAX_X: prdata = mxx_reg;
            src_pkg::REG_MIN_Y: prdata = mny_reg;
            src_pkg::REG_MAX_Y: prdata = mxy_reg;
            default:            prdata = '0;
        endcase
    end

    // pipeline control
    logic advance;

    assign advance   = !clip_valid || !clip_stall;
    assign seg_stall = !advance;

    // stage 1: differences and region tests
    logic               s1_valid_reg;
    src_pkg::seg_t      s1_seg_reg;
    logic               s1_in1_reg, s1_inside_reg, s1_reject_reg;
    src_pkg::side_in_t  side_in_reg [NS];
    src_pkg::side_in_t  side_in_next [NS];
    logic               in1_next, in2_next, reject_next;
    logic signed [DW-1:0] dx, dy;

    always_comb
    begin
        dx = dif(seg.end_x, seg.start_x);
        dy = dif(seg.end_y, seg.start_y);
        in1_next = seg.start_x >= mnx_reg && seg.start_x <= mxx_reg &&
                   seg.start_y >= mny_reg && seg.start_y <= mxy_reg;
        in2_next = seg.end_x >= mnx_reg && seg.end_x <= mxx_reg &&
                   seg.end_y >= mny_reg && seg.end_y <= mxy_reg;
        reject_next = (seg.start_x > mxx_reg && seg.end_x > mxx_reg) ||
                      (seg.start_x < mnx_reg && seg.end_x < mnx_reg) ||
                      (seg.start_y > mxy_reg && seg.end_y > mxy_reg) ||
                      (seg.start_y < mny_reg && seg.end_y < mny_reg);

        side_in_next[0].len = dif(mxy_reg, mny_reg);
        side_in_next[0].a   = dif(mnx_reg, seg.start_x);
        side_in_next[0].w   = dif(seg.start_y, mny_reg);
        side_in_next[0].du  = dx;
        side_in_next[0].dv  = dy;
        side_in_next[0].v1  = seg.start_y;

        side_in_next[1].len = dif(mxx_reg, mnx_reg);
        side_in_next[1].a   = dif(mxy_reg, seg.start_y);
        side_in_next[1].w   = dif(seg.start_x, mnx_reg);
        side_in_next[1].du  = dy;
        side_in_next[1].dv  = dx;
        side_in_next[1].v1  = seg.start_x;

        side_in_next[2].len = dif(mny_reg, mxy_reg);
        side_in_next[2].a   = dif(mxx_reg, seg.start_x);
        side_in_next[2].w   = dif(seg.start_y, mxy_reg);
        side_in_next[2].du  = dx;
        side_in_next[2].dv  = dy;
        side_in_next[2].v1  = seg.start_y;

        side_in_next[3].len = dif(mnx_reg, mxx_reg);
        side_in_next[3].a   = dif(mny_reg, seg.start_y);
        side_in_next[3].w   = dif(seg.start_x, mxx_reg);
        side_in_next[3].du  = dy;
        side_in_next[3].dv  = dx;
        side_in_next[3].v1  = seg.start_x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance)
            s1_valid_reg <= seg_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_seg_reg    <= seg;
            s1_in1_reg    <= in1_next;
            s1_inside_reg <= in1_next && in2_next;
            s1_reject_reg <= reject_next;
            for (int k = 0; k < NS; k++)
                side_in_reg[k] <= side_in_next[k];
        end
    end

    // side units
    src_pkg::side_out_t side_out [NS];

    genvar s;
    generate
        for (s = 0; s < NS; s++)
        begin : g_side
            src_side u_side (
                .clk      (clk),
                .en       (advance),
                .side_in  (side_in_reg[s]),
                .side_out (side_out[s])
            );
        end
    endgenerate

    // sideband delay matching the side units
    logic          vld_pipe_reg    [LAT];
    src_pkg::seg_t seg_pipe_reg    [LAT];
    logic          in1_pipe_reg    [LAT];
    logic          inside_pipe_reg [LAT];
    logic          reject_pipe_reg [LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_pipe_reg[k] <= 1'b0;
        end
        else if (advance)
        begin
            vld_pipe_reg[0] <= s1_valid_reg;
            for (int k = 1; k < LAT; k++)
                vld_pipe_reg[k] <= vld_pipe_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            seg_pipe_reg[0]    <= s1_seg_reg;
            in1_pipe_reg[0]    <= s1_in1_reg;
            inside_pipe_reg[0] <= s1_inside_reg;
            reject_pipe_reg[0] <= s1_reject_reg;
            for (int k = 1; k < LAT; k++)
            begin
                seg_pipe_reg[k]    <= seg_pipe_reg[k-1];
                in1_pipe_reg[k]    <= in1_pipe_reg[k-1];
                inside_pipe_reg[k] <= inside_pipe_reg[k-1];
                reject_pipe_reg[k] <= reject_pipe_reg[k-1];
            end
        end
    end

    // merge hits in side order, keep the first two
    src_pkg::clip_t clip_reg, clip_next;
    logic           clip_valid_reg;
    src_pkg::seg_t  sg;
    logic signed [CW-1:0] px [NS];
    logic signed [CW-1:0] py [NS];
    logic signed [CW-1:0] h0x, h0y, h1x, h1y;
    logic [1:0]     cnt;

    always_comb
    begin
        sg = seg_pipe_reg[LAT-1];
        px[0] = mnx_reg;        py[0] = side_out[0].hv;
        px[1] = side_out[1].hv; py[1] = mxy_reg;
        px[2] = mxx_reg;        py[2] = side_out[2].hv;
        px[3] = side_out[3].hv; py[3] = mny_reg;
        cnt = 2'd0;
        h0x = '0; h0y = '0; h1x = '0; h1y = '0;
        for (int k = 0; k < NS; k++)
        begin
            if (side_out[k].hit && cnt == 2'd0)
            begin
                h0x = px[k];
                h0y = py[k];
                cnt = 2'd1;
            end
            else if (side_out[k].hit && cnt == 2'd1)
            begin
                h1x = px[k];
                h1y = py[k];
                cnt = 2'd2;
            end
        end

        clip_next.clip_status = src_pkg::ST_OUTSIDE;
        clip_next.out_start_x = sg.start_x;
        clip_next.out_start_y = sg.start_y;
        clip_next.out_end_x   = sg.end_x;
        clip_next.out_end_y   = sg.end_y;
        if (inside_pipe_reg[LAT-1])
            clip_next.clip_status = src_pkg::ST_INSIDE;
        else if (!reject_pipe_reg[LAT-1])
        begin
            case (cnt)
                2'd1:
                begin
                    if (in1_pipe_reg[LAT-1])
                    begin
                        clip_next.clip_status = src_pkg::ST_END;
                        clip_next.out_end_x   = h0x;
                        clip_next.out_end_y   = h0y;
                    end
                    else
                    begin
                        clip_next.clip_status = src_pkg::ST_START;
                        clip_next.out_start_x = h0x;
                        clip_next.out_start_y = h0y;
                    end
                end
                2'd2:
                begin
                    clip_next.clip_status = src_pkg::ST_BOTH;
                    clip_next.out_start_x = h0x;
                    clip_next.out_start_y = h0y;
                    clip_next.out_end_x   = h1x;
                    clip_next.out_end_y   = h1y;
                end
                default:
                begin
                    clip_next.clip_status = src_pkg::ST_OUTSIDE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clip_valid_reg <= 1'b0;
        else if (advance)
            clip_valid_reg <= vld_pipe_reg[LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            clip_reg <= clip_next;
    end

    assign clip_valid = clip_valid_reg;
    assign clip       = clip_reg;

endmodule

`default_nettype wire
